// File: rtl/hfjn_pkg.sv
package hfjn_pkg;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_TPOS_X = 3'd0;
    localparam logic [2:0] REG_TPOS_Y = 3'd1;
    localparam logic [2:0] REG_TPOS_Z = 3'd2;
    localparam logic [2:0] REG_TVEL_X = 3'd3;
    localparam logic [2:0] REG_TVEL_Y = 3'd4;
    localparam logic [2:0] REG_TVEL_Z = 3'd5;
    localparam logic [2:0] REG_RADSQ  = 3'd6;
    localparam logic [2:0] REG_TINDEX = 3'd7;

    localparam int IN_W  = 432;
    localparam int OUT_W = 224;

    // one source item as it leaves the front queue
    typedef struct packed {
        logic [2:0][63:0] pos;
        logic [2:0][63:0] vel;
        logic [31:0]      mass;
        logic [11:0]      index;
        logic             skip;
        logic             last;
    } src_item_t;

    // target particle settings
    typedef struct packed {
        logic [2:0][63:0] tpos;
        logic [2:0][63:0] tvel;
        logic [63:0]      radsq;
        logic [11:0]      tindex;
    } target_cfg_t;

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] satsign(input logic neg, input logic [127:0] m);
        logic [63:0] lim;
        lim = neg ? SMIN : SMAX;
        if (m[127:64] == 64'd0 && m[63:0] <= lim)
            return neg ? (64'd0 - m[63:0]) : m[63:0];
        return lim;
    endfunction

    // Q32.32 product from an unsigned magnitude product
    function automatic logic [63:0] qsat(input logic neg, input logic [127:0] p);
        return satsign(neg, {32'd0, p[127:32]});
    endfunction

    function automatic logic add_ovf(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        return (~(a[63] ^ b[63])) & (a[63] ^ r[63]);
    endfunction

    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        if (add_ovf(a, b))
            return a[63] ? SMIN : SMAX;
        return a + b;
    endfunction

    function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if ((a[63] ^ b[63]) & (a[63] ^ r[63]))
            return a[63] ? SMIN : SMAX;
        return r;
    endfunction

endpackage

// File: rtl/hfjn_front.sv
module hfjn_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [hfjn_pkg::IN_W-1:0] s_tdata,
    input  logic                     s_tlast,
    input  logic [11:0]              tindex,
    output hfjn_pkg::src_item_t      item,
    output logic                     item_valid,
    input  logic                     item_pop
);
    import hfjn_pkg::*;

    src_item_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    src_item_t   incoming;
    logic        push;
    logic        pop;

    // unpack and classify the incoming transaction
    always_comb
    begin
        incoming.pos[0] = s_tdata[63:0];
        incoming.pos[1] = s_tdata[127:64];
        incoming.pos[2] = s_tdata[191:128];
        incoming.vel[0] = s_tdata[255:192];
        incoming.vel[1] = s_tdata[319:256];
        incoming.vel[2] = s_tdata[383:320];
        incoming.mass   = s_tdata[415:384];
        incoming.index  = s_tdata[427:416];
        incoming.skip   = !s_tdata[428] || (s_tdata[427:416] == tindex);
        incoming.last   = s_tlast;
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = entry_reg[rd_ptr_reg];

    // hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// File: rtl/hfjn_mul.sv
module hfjn_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] p
);
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // select one 32x32 partial product per cycle
    always_comb
    begin
        op_a  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        op_b  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp    = {32'd0, op_a} * {32'd0, op_b};
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    assign done = done_reg;
    assign p    = acc_reg;

    // hold operands and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 2'd0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/hfjn_divsqrt.sv
module hfjn_divsqrt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         sqrt_mode,
    input  logic [127:0] num,
    input  logic [127:0] den,
    output logic         done,
    output logic [127:0] quo,
    output logic [63:0]  root
);
    logic         mode_reg;
    logic [127:0] n_reg;
    logic [127:0] d_reg;
    logic [127:0] r_reg;
    logic [127:0] q_reg;
    logic [6:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [127:0] r_sh;
    logic         div_ge;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         sq_ge;
    logic [67:0]  rem_dif;
    logic [6:0]   last_cnt;

    // one restoring step: a quotient bit or a root bit
    always_comb
    begin
        r_sh    = {r_reg[126:0], n_reg[127]};
        div_ge  = (r_sh >= d_reg);
        rem_sh  = {r_reg[65:0], n_reg[127:126]};
        trial   = {2'b00, q_reg[63:0], 2'b01};
        sq_ge   = (rem_sh >= trial);
        rem_dif = rem_sh - trial;
        last_cnt = mode_reg ? 7'd63 : 7'd127;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign root = q_reg[63:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= sqrt_mode;
            n_reg    <= num;
            d_reg    <= den;
            r_reg    <= 128'd0;
            q_reg    <= 128'd0;
        end
        else if (run_reg)
        begin
            if (mode_reg)
            begin
                n_reg <= {n_reg[125:0], 2'b00};
                r_reg <= {62'd0, sq_ge ? rem_dif[65:0] : rem_sh[65:0]};
                q_reg <= {q_reg[126:0], sq_ge};
            end
            else
            begin
                n_reg <= {n_reg[126:0], 1'b0};
                r_reg <= div_ge ? (r_sh - d_reg) : r_sh;
                q_reg <= {q_reg[126:0], div_ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 7'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 7'd0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == last_cnt)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/hfjn_back.sv
module hfjn_back #(
    parameter int MAX_PARTICLES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hfjn_pkg::target_cfg_t      cfg,
    input  hfjn_pkg::src_item_t        item,
    input  logic                       item_valid,
    output logic                       item_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [hfjn_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import hfjn_pkg::*;

    localparam int NCAP = ((MAX_PARTICLES - 1) < 4095) ? (MAX_PARTICLES - 1) : 4095;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DIFF  = 13'b0000000000010,
        S_R2    = 13'b0000000000100,
        S_SQRT  = 13'b0000000001000,
        S_DEN   = 13'b0000000010000,
        S_KDIV  = 13'b0000000100000,
        S_VX    = 13'b0000001000000,
        S_QDIV  = 13'b0000010000000,
        S_TQ    = 13'b0000100000000,
        S_JK    = 13'b0001000000000,
        S_ACC   = 13'b0010000000000,
        S_NBR   = 13'b0100000000000,
        S_FORCE = 13'b1000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic          busy_reg, busy_next;
    logic [2:0]    sel_reg, sel_next;
    src_item_t     src_reg, src_next;
    logic [63:0]   dx_reg [3];
    logic [63:0]   dx_next [3];
    logic [63:0]   dv_reg [3];
    logic [63:0]   dv_next [3];
    logic [63:0]   r2_reg, r2_next;
    logic [63:0]   rq_reg, rq_next;
    logic [127:0]  den_reg, den_next;
    logic [63:0]   k_reg, k_next;
    logic [63:0]   vx_reg, vx_next;
    logic [63:0]   q_reg, q_next;
    logic [63:0]   e_reg, e_next;
    logic          far_reg, far_next;
    logic [63:0]   rsum_reg [6];
    logic [63:0]   rsum_next [6];
    logic [63:0]   isum_reg [6];
    logic [63:0]   isum_next [6];
    logic [11:0]   ncnt_reg, ncnt_next;
    logic          sat_reg, sat_next;

    logic          mul_start;
    logic [63:0]   mul_a;
    logic [63:0]   mul_b;
    logic          mul_done;
    logic [127:0]  mul_p;
    logic          ds_start;
    logic          ds_sqrt;
    logic [127:0]  ds_num;
    logic [127:0]  ds_den;
    logic          ds_done;
    logic [127:0]  ds_quo;
    logic [63:0]   ds_root;

    logic [1:0]    d;
    logic [2:0]    rd_addr;
    logic [63:0]   rsum_rd;
    logic [63:0]   isum_rd;
    logic [63:0]   cur_sum;
    logic          prod_neg;
    logic [63:0]   qm;
    logic [63:0]   sq_term;
    logic [64:0]   r2_sum;
    logic [63:0]   r2_new;
    logic [63:0]   t3;
    logic [2:0]    wr_addr;
    logic          ovf;
    logic [63:0]   upd;
    logic [63:0]   tot;

    hfjn_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    hfjn_divsqrt u_divsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ds_start),
        .sqrt_mode (ds_sqrt),
        .num       (ds_num),
        .den       (ds_den),
        .done      (ds_done),
        .quo       (ds_quo),
        .root      (ds_root)
    );

    // read the sums at the single shared address
    always_comb
    begin
        d        = sel_reg[2:1];
        rd_addr  = (state_reg == S_FORCE) ? sel_reg : {d, state_reg == S_JK};
        rsum_rd  = rsum_reg[rd_addr];
        isum_rd  = isum_reg[rd_addr];
        cur_sum  = far_reg ? rsum_rd : isum_rd;
        tot      = sadd(rsum_rd, isum_rd);
    end

    // sequence the pair arithmetic
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        sel_next   = sel_reg;
        src_next   = src_reg;
        dx_next    = dx_reg;
        dv_next    = dv_reg;
        r2_next    = r2_reg;
        rq_next    = rq_reg;
        den_next   = den_reg;
        k_next     = k_reg;
        vx_next    = vx_reg;
        q_next     = q_reg;
        e_next     = e_reg;
        far_next   = far_reg;
        rsum_next  = rsum_reg;
        isum_next  = isum_reg;
        ncnt_next  = ncnt_reg;
        sat_next   = sat_reg;
        item_pop   = 1'b0;
        mul_start  = 1'b0;
        mul_a      = 64'd0;
        mul_b      = 64'd0;
        ds_start   = 1'b0;
        ds_sqrt    = 1'b0;
        ds_num     = 128'd0;
        ds_den     = 128'd0;
        prod_neg   = 1'b0;

        // operand selection for the shared units
        unique case (state_reg)
            S_R2:
            begin
                mul_a = mag64(dx_reg[d]);
                mul_b = mag64(dx_reg[d]);
            end
            S_SQRT:
            begin
                ds_sqrt = 1'b1;
                ds_num  = {32'd0, r2_reg, 32'd0};
            end
            S_DEN:
            begin
                mul_a = r2_reg;
                mul_b = rq_reg;
            end
            S_KDIV:
            begin
                ds_num = {32'd0, src_reg.mass, 64'd0};
                ds_den = den_reg;
            end
            S_VX:
            begin
                mul_a    = mag64(dv_reg[d]);
                mul_b    = mag64(dx_reg[d]);
                prod_neg = dv_reg[d][63] ^ dx_reg[d][63];
            end
            S_QDIV:
            begin
                ds_num = {32'd0, mag64(vx_reg), 32'd0};
                ds_den = {64'd0, r2_reg};
            end
            S_TQ:
            begin
                mul_a    = mag64(dx_reg[d]);
                mul_b    = mag64(q_reg);
                prod_neg = dx_reg[d][63] ^ q_reg[63];
            end
            S_JK:
            begin
                mul_a    = mag64(k_reg);
                mul_b    = mag64(e_reg);
                prod_neg = k_reg[63] ^ e_reg[63];
            end
            S_ACC:
            begin
                mul_a    = mag64(k_reg);
                mul_b    = mag64(dx_reg[d]);
                prod_neg = k_reg[63] ^ dx_reg[d][63];
            end
            default:
            begin
            end
        endcase

        qm      = qsat(prod_neg, mul_p);
        sq_term = (mul_p[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : mul_p[95:32];
        r2_sum  = {1'b0, r2_reg} + {1'b0, sq_term};
        r2_new  = r2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : r2_sum[63:0];
        t3      = sadd(sadd(qm, qm), qm);
        wr_addr = {d, state_reg == S_JK};
        ovf     = add_ovf(cur_sum, qm);
        upd     = sadd(cur_sum, qm);

        // issue a start for each unit operation of a compute state
        if (state_reg == S_R2 || state_reg == S_DEN || state_reg == S_VX ||
            state_reg == S_TQ || state_reg == S_JK || state_reg == S_ACC)
        begin
            if (!busy_reg)
            begin
                mul_start = 1'b1;
                busy_next = 1'b1;
            end
            else if (mul_done)
            begin
                busy_next = 1'b0;
            end
        end
        if (state_reg == S_SQRT || state_reg == S_KDIV || state_reg == S_QDIV)
        begin
            if (!busy_reg)
            begin
                ds_start  = 1'b1;
                busy_next = 1'b1;
            end
            else if (ds_done)
            begin
                busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    src_next = item;
                    sel_next = 3'd0;
                    if (!item.skip)
                        state_next = S_DIFF;
                    else if (item.last)
                        state_next = S_FORCE;
                end
            end
            S_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dx_next[i] = ssub(src_reg.pos[i], cfg.tpos[i]);
                    dv_next[i] = ssub(src_reg.vel[i], cfg.tvel[i]);
                end
                r2_next    = 64'd0;
                sel_next   = 3'd0;
                state_next = S_R2;
            end
            S_R2:
            begin
                if (busy_reg && mul_done)
                begin
                    r2_next = r2_new;
                    if (d == 2'd2)
                    begin
                        sel_next = 3'd0;
                        far_next = (r2_new > cfg.radsq);
                        if (r2_new != 64'd0)
                            state_next = S_SQRT;
                        else
                            state_next = src_reg.last ? S_FORCE : S_IDLE;
                    end
                    else
                    begin
                        sel_next = {d + 2'd1, 1'b0};
                    end
                end
            end
            S_SQRT:
            begin
                if (busy_reg && ds_done)
                begin
                    rq_next    = ds_root;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                if (busy_reg && mul_done)
                begin
                    den_next   = mul_p;
                    state_next = S_KDIV;
                end
            end
            S_KDIV:
            begin
                if (busy_reg && ds_done)
                begin
                    k_next     = satsign(1'b0, ds_quo);
                    vx_next    = 64'd0;
                    sel_next   = 3'd0;
                    state_next = S_VX;
                end
            end
            S_VX:
            begin
                if (busy_reg && mul_done)
                begin
                    vx_next = sadd(vx_reg, qm);
                    if (d == 2'd2)
                    begin
                        sel_next   = 3'd0;
                        state_next = S_QDIV;
                    end
                    else
                    begin
                        sel_next = {d + 2'd1, 1'b0};
                    end
                end
            end
            S_QDIV:
            begin
                if (busy_reg && ds_done)
                begin
                    q_next     = satsign(vx_reg[63], ds_quo);
                    state_next = S_TQ;
                end
            end
            S_TQ:
            begin
                if (busy_reg && mul_done)
                begin
                    e_next     = ssub(dv_reg[d], t3);
                    state_next = S_JK;
                end
            end
            S_JK, S_ACC:
            begin
                if (busy_reg && mul_done)
                begin
                    if (far_reg)
                        rsum_next[wr_addr] = upd;
                    else
                        isum_next[wr_addr] = upd;
                    if (ovf)
                        sat_next = 1'b1;
                    if (state_reg == S_JK)
                    begin
                        state_next = S_ACC;
                    end
                    else if (d != 2'd2)
                    begin
                        sel_next   = {d + 2'd1, 1'b0};
                        state_next = S_TQ;
                    end
                    else if (!far_reg)
                    begin
                        if (ncnt_reg < 12'(NCAP))
                            ncnt_next = ncnt_reg + 12'd1;
                        state_next = S_NBR;
                    end
                    else
                    begin
                        sel_next   = 3'd0;
                        state_next = src_reg.last ? S_FORCE : S_IDLE;
                    end
                end
            end
            S_NBR:
            begin
                if (m_tready)
                begin
                    sel_next   = 3'd0;
                    state_next = src_reg.last ? S_FORCE : S_IDLE;
                end
            end
            S_FORCE:
            begin
                if (m_tready)
                begin
                    if (sel_reg == 3'd5)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            rsum_next[i] = 64'd0;
                            isum_next[i] = 64'd0;
                        end
                        ncnt_next  = 12'd0;
                        sat_next   = 1'b0;
                        sel_next   = 3'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // drive the result transaction
    always_comb
    begin
        m_tvalid = (state_reg == S_NBR) || (state_reg == S_FORCE);
        m_tuser  = (state_reg == S_FORCE);
        m_tlast  = (state_reg == S_FORCE) && (sel_reg == 3'd5);
        m_tdata  = '0;
        m_tdata[218:207] = ncnt_reg;
        m_tdata[219]     = sat_reg;
        if (state_reg == S_FORCE)
        begin
            m_tdata[1:0]     = sel_reg[2:1];
            m_tdata[2]       = sel_reg[0];
            m_tdata[66:3]    = rsum_rd;
            m_tdata[130:67]  = isum_rd;
            m_tdata[194:131] = tot;
        end
        else
        begin
            m_tdata[206:195] = src_reg.index;
        end
    end

    // hold working values
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dx_reg  <= dx_next;
        dv_reg  <= dv_next;
        r2_reg  <= r2_next;
        rq_reg  <= rq_next;
        den_reg <= den_next;
        k_reg   <= k_next;
        vx_reg  <= vx_next;
        q_reg   <= q_next;
        e_reg   <= e_next;
        far_reg <= far_next;
    end

    // advance control state and sweep sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            sel_reg   <= 3'd0;
            ncnt_reg  <= 12'd0;
            sat_reg   <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                rsum_reg[i] <= 64'd0;
                isum_reg[i] <= 64'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            sel_reg   <= sel_next;
            ncnt_reg  <= ncnt_next;
            sat_reg   <= sat_next;
            rsum_reg  <= rsum_next;
            isum_reg  <= isum_next;
        end
    end

endmodule

// File: rtl/hermite_force_jerk_neighbor_split.sv
// Hermite force and jerk accumulator with a neighbor-radius split. Program the
// target particle through the write port, then stream source particles in; a
// two-entry front queue takes sources while the back end works. An inactive or
// self source is skipped and a coincident one stops after the squared distance;
// the time of a full pair is set by the shared bit-serial divide/square-root
// unit (one root and two divides) and the 64x64 multiplier, used sixteen times.
// Each neighbor adds one result transaction; the source marked last adds six
// force transactions (x, y, z; acceleration then jerk) and clears the sweep state.
module hermite_force_jerk_neighbor_split #(
    parameter int MAX_PARTICLES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_addr,
    input  logic [63:0]                cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // src_pos_x, src_pos_y, src_pos_z, src_vel_x, src_vel_y, src_vel_z,
    // src_mass, src_index, src_active, 3 zero bits
    input  logic [hfjn_pkg::IN_W-1:0]  s_tdata,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // dim, order, reg_value, irr_value, tot_value, neighbor_index,
    // neighbor_count, saturated, 4 zero bits
    output logic [hfjn_pkg::OUT_W-1:0] m_tdata,
    // kind
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import hfjn_pkg::*;

    target_cfg_t cfg_reg;
    src_item_t   item;
    logic        item_valid;
    logic        item_pop;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TPOS_X: cfg_reg.tpos[0] <= cfg_wdata;
                REG_TPOS_Y: cfg_reg.tpos[1] <= cfg_wdata;
                REG_TPOS_Z: cfg_reg.tpos[2] <= cfg_wdata;
                REG_TVEL_X: cfg_reg.tvel[0] <= cfg_wdata;
                REG_TVEL_Y: cfg_reg.tvel[1] <= cfg_wdata;
                REG_TVEL_Z: cfg_reg.tvel[2] <= cfg_wdata;
                REG_RADSQ:  cfg_reg.radsq   <= cfg_wdata;
                REG_TINDEX: cfg_reg.tindex  <= cfg_wdata[11:0];
                default:    cfg_reg         <= cfg_reg;
            endcase
        end
    end

    hfjn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .tindex     (cfg_reg.tindex),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    hfjn_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
